[sv/tsfb_pkg.sv]
// Shared types, constants and helpers for the TCP SYN frame builder.
// No dependencies; every other file of the block but tsfb_checker refers to this package.
package tsfb_pkg;

  localparam int FRAME_BYTES = 54;
  localparam int FRAME_W     = FRAME_BYTES * 8;
  localparam int CNT_W       = $clog2(FRAME_BYTES);
  localparam int SUM_W       = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam logic [15:0] PSEUDO_PROTO = 16'd6;
  localparam logic [15:0] PSEUDO_LEN   = 16'd20;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_MAC    = 3'd0,
    REG_DEST_MAC      = 3'd1,
    REG_SOURCE_IP     = 3'd2,
    REG_DEST_IP       = 3'd3,
    REG_ETHER_KIND    = 3'd4,
    REG_IP_FIRST_WORD = 3'd5,
    REG_HOP_AND_PROTO = 3'd6,
    REG_OFFSET_SHIFT  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] ether_kind;
    logic [15:0] ip_first_word;
    logic [15:0] hop_and_proto;
    logic [2:0]  offset_shift;
  } cfg_t;

  typedef struct packed {
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [7:0]  offset_value;
    logic [7:0]  tcp_flags;
    logic [15:0] window_size;
    logic [15:0] urgent_pointer;
    logic [15:0] ip_ident;
    logic [15:0] frag_field;
    logic [15:0] total_length;
  } req_t;

  function automatic logic [SUM_W-1:0] ext16(input logic [15:0] w);
    ext16 = {{(SUM_W-16){1'b0}}, w};
  endfunction

  function automatic logic [15:0] fold_invert(input logic [SUM_W-1:0] s);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, s[15:0]} + {{(17-(SUM_W-16)){1'b0}}, s[SUM_W-1:16]};
    s2 = s1[15:0] + {15'd0, s1[16]};
    fold_invert = ~s2;
  endfunction

endpackage

[sv/tsfb_csum_pipe.sv]
// Three-stage checksum pipeline: partial sums, full sums, fold and frame assembly.
// Depends on tsfb_pkg.
module tsfb_csum_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsfb_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tsfb_pkg::req_t                in_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsfb_pkg::FRAME_W-1:0]  out_frame
);

  logic                        v1_r, v2_r, v3_r;
  logic                        rdy1, rdy2, rdy3;
  tsfb_pkg::req_t              req1_r, req2_r, req3_r;
  logic [7:0]                  off1_r, off2_r, off3_r;
  logic [7:0]                  off_nxt;
  logic [tsfb_pkg::SUM_W-1:0]  ip_a_r, tcp_a_r, ip_a_nxt, tcp_a_nxt;
  logic [tsfb_pkg::SUM_W-1:0]  ip_sum_r, tcp_sum_r, ip_sum_nxt, tcp_sum_nxt, addr_sum;
  logic [15:0]                 ip_csum_r, tcp_csum_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    off_nxt   = 8'(in_req.offset_value << cfg.offset_shift);
    ip_a_nxt  = tsfb_pkg::ext16(cfg.ip_first_word) + tsfb_pkg::ext16(in_req.total_length)
              + tsfb_pkg::ext16(in_req.ip_ident) + tsfb_pkg::ext16(in_req.frag_field)
              + tsfb_pkg::ext16(cfg.hop_and_proto);
    tcp_a_nxt = tsfb_pkg::ext16(in_req.source_port) + tsfb_pkg::ext16(in_req.dest_port)
              + tsfb_pkg::ext16(in_req.seq_number[31:16])
              + tsfb_pkg::ext16(in_req.seq_number[15:0])
              + tsfb_pkg::ext16(in_req.ack_number[31:16])
              + tsfb_pkg::ext16(in_req.ack_number[15:0]);
  end

  always_comb begin
    addr_sum    = tsfb_pkg::ext16(cfg.source_ip[31:16]) + tsfb_pkg::ext16(cfg.source_ip[15:0])
                + tsfb_pkg::ext16(cfg.dest_ip[31:16]) + tsfb_pkg::ext16(cfg.dest_ip[15:0]);
    ip_sum_nxt  = ip_a_r + addr_sum;
    tcp_sum_nxt = tcp_a_r + addr_sum + tsfb_pkg::ext16(tsfb_pkg::PSEUDO_PROTO)
                + tsfb_pkg::ext16(tsfb_pkg::PSEUDO_LEN)
                + tsfb_pkg::ext16({off1_r, req1_r.tcp_flags})
                + tsfb_pkg::ext16(req1_r.window_size)
                + tsfb_pkg::ext16(req1_r.urgent_pointer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      req1_r  <= in_req;
      off1_r  <= off_nxt;
      ip_a_r  <= ip_a_nxt;
      tcp_a_r <= tcp_a_nxt;
    end
    if (rdy2 && v1_r) begin
      req2_r    <= req1_r;
      off2_r    <= off1_r;
      ip_sum_r  <= ip_sum_nxt;
      tcp_sum_r <= tcp_sum_nxt;
    end
    if (rdy3 && v2_r) begin
      req3_r     <= req2_r;
      off3_r     <= off2_r;
      ip_csum_r  <= tsfb_pkg::fold_invert(ip_sum_r);
      tcp_csum_r <= tsfb_pkg::fold_invert(tcp_sum_r);
    end
  end

  assign out_valid = v3_r;
  assign out_frame = {cfg.dest_mac, cfg.source_mac, cfg.ether_kind,
                      cfg.ip_first_word, req3_r.total_length, req3_r.ip_ident,
                      req3_r.frag_field, cfg.hop_and_proto, ip_csum_r,
                      cfg.source_ip, cfg.dest_ip,
                      req3_r.source_port, req3_r.dest_port, req3_r.seq_number,
                      req3_r.ack_number, off3_r, req3_r.tcp_flags,
                      req3_r.window_size, tcp_csum_r, req3_r.urgent_pointer};

endmodule

[sv/tsfb_serializer.sv]
// Frame shift register: loads a 54-byte frame and sends it one byte per transaction.
// Depends on tsfb_pkg.
module tsfb_serializer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tsfb_pkg::FRAME_W-1:0]  in_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);

  logic [tsfb_pkg::FRAME_W-1:0] frame_r;
  logic [tsfb_pkg::CNT_W-1:0]   cnt_r;
  logic                         busy_r;
  logic                         last, load, take;

  assign last      = (cnt_r == tsfb_pkg::LAST_CNT);
  assign take      = busy_r && out_ready;
  assign in_ready  = !busy_r || (out_ready && last);
  assign load      = in_valid && in_ready;
  assign out_valid = busy_r;
  assign out_byte  = frame_r[tsfb_pkg::FRAME_W-1 -: 8];
  assign out_last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (take) begin
        if (last) begin
          busy_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= in_frame;
    end else if (take) begin
      frame_r <= {frame_r[tsfb_pkg::FRAME_W-9:0], 8'd0};
    end
  end

endmodule

[sv/tcp_syn_frame_builder_unit.sv]
// Top level of the TCP SYN frame builder: configuration registers, checksum pipe, serializer.
// Depends on tsfb_pkg, tsfb_csum_pipe and tsfb_serializer.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid/in_ready     TCP and IPv4 per-packet fields
//   out_     result     out_valid/out_ready   out_frame_byte, out_last_byte
//   cfg_     write      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Each request yields 54 output bytes, one per cycle while out_ready is high; the
// serializer loads the next frame as the last byte of the current frame is taken.
// With the serializer idle, the first byte follows the checksum stages and the load.
// Three checksum stages buffer further requests while a frame is being sent.
// Synchronous active-low reset clears valids and loads register reset values.
// Stalls on out_ready hold the serializer and back up the stages behind it; nothing is lost or repeated.
module tcp_syn_frame_builder_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [15:0]                        in_source_port,
  input  logic [15:0]                        in_dest_port,
  input  logic [31:0]                        in_seq_number,
  input  logic [31:0]                        in_ack_number,
  input  logic [7:0]                         in_offset_value,
  input  logic [7:0]                         in_tcp_flags,
  input  logic [15:0]                        in_window_size,
  input  logic [15:0]                        in_urgent_pointer,
  input  logic [15:0]                        in_ip_ident,
  input  logic [15:0]                        in_frag_field,
  input  logic [15:0]                        in_total_length,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_frame_byte,
  output logic                               out_last_byte,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tsfb_pkg::cfg_t             cfg_r;
  tsfb_pkg::req_t             req;
  logic                       pipe_valid, pipe_ready;
  logic [tsfb_pkg::FRAME_W-1:0] pipe_frame;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_mac    <= '0;
      cfg_r.dest_mac      <= '0;
      cfg_r.source_ip     <= '0;
      cfg_r.dest_ip       <= '0;
      cfg_r.ether_kind    <= 16'h0800;
      cfg_r.ip_first_word <= 16'h4500;
      cfg_r.hop_and_proto <= 16'h4006;
      cfg_r.offset_shift  <= 3'd4;
    end else if (cfg_valid) begin
      unique case (tsfb_pkg::cfg_idx_t'(cfg_index))
        tsfb_pkg::REG_SOURCE_MAC:    cfg_r.source_mac    <= cfg_data;
        tsfb_pkg::REG_DEST_MAC:      cfg_r.dest_mac      <= cfg_data;
        tsfb_pkg::REG_SOURCE_IP:     cfg_r.source_ip     <= cfg_data[31:0];
        tsfb_pkg::REG_DEST_IP:       cfg_r.dest_ip       <= cfg_data[31:0];
        tsfb_pkg::REG_ETHER_KIND:    cfg_r.ether_kind    <= cfg_data[15:0];
        tsfb_pkg::REG_IP_FIRST_WORD: cfg_r.ip_first_word <= cfg_data[15:0];
        tsfb_pkg::REG_HOP_AND_PROTO: cfg_r.hop_and_proto <= cfg_data[15:0];
        tsfb_pkg::REG_OFFSET_SHIFT:  cfg_r.offset_shift  <= cfg_data[2:0];
      endcase
    end
  end

  always_comb begin
    req.source_port    = in_source_port;
    req.dest_port      = in_dest_port;
    req.seq_number     = in_seq_number;
    req.ack_number     = in_ack_number;
    req.offset_value   = in_offset_value;
    req.tcp_flags      = in_tcp_flags;
    req.window_size    = in_window_size;
    req.urgent_pointer = in_urgent_pointer;
    req.ip_ident       = in_ip_ident;
    req.frag_field     = in_frag_field;
    req.total_length   = in_total_length;
  end

  tsfb_csum_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (req),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_frame (pipe_frame)
  );

  tsfb_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pipe_valid),
    .in_ready  (pipe_ready),
    .in_frame  (pipe_frame),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_frame_byte),
    .out_last  (out_last_byte)
  );

endmodule

[sv/tsfb_checker.sv]
// Port-level checks for the TCP SYN frame builder, bound to the top level.
// Depends on tcp_syn_frame_builder_unit.
module tsfb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [7:0]                         out_frame_byte,
  input logic                               out_last_byte
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
                                && $stable(out_last_byte))
    else $error("stalled output transaction changed");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=> out_valid)
    else $error("gap inside a frame");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_last_byte)
    else $error("frame started on its last byte");

endmodule

bind tcp_syn_frame_builder_unit tsfb_checker u_tsfb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_byte (out_frame_byte),
  .out_last_byte  (out_last_byte)
);
